// File: sv/tksr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tksr_pkg;

  localparam int ID_W     = 16;
  localparam int IN_SC_W  = 16;
  localparam int K_W      = 7;
  localparam int AVG_W    = 24;
  localparam int FRAC_W   = 8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_TOPK   = 2'd1,
    OP_RANGE  = 2'd2,
    OP_AVG    = 2'd3
  } op_e_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_e_t;

  // one decoded command waiting for the back end
  typedef struct packed {
    op_e_t              kind;
    logic [ID_W-1:0]    entry_id;
    logic [IN_SC_W-1:0] entry_score;
    logic [K_W-1:0]     top_count;
    logic [IN_SC_W-1:0] range_low;
    logic [IN_SC_W-1:0] range_high;
  } cmd_t;

endpackage
`default_nettype wire

// File: sv/tksr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module tksr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/tksr_front.sv
`timescale 1ns / 1ps
`default_nettype none
module tksr_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic [1:0]           in_op,
  input  wire logic [15:0]          in_entry_id,
  input  wire logic [15:0]          in_entry_score,
  input  wire logic [6:0]           in_top_count,
  input  wire logic [15:0]          in_range_low,
  input  wire logic [15:0]          in_range_high,
  output logic                      cmd_valid,
  output tksr_pkg::cmd_t            cmd,
  input  wire logic                 cmd_pop
);
  import tksr_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       acc;
  cmd_t       dec;

  // decode the opcode into a command
  always_comb begin
    dec.kind        = op_e_t'(in_op);
    dec.entry_id    = in_entry_id;
    dec.entry_score = in_entry_score;
    dec.top_count   = in_top_count;
    dec.range_low   = in_range_low;
    dec.range_high  = in_range_high;
  end

  assign in_full   = (cnt_r == 2'd2);
  assign acc       = in_push && !in_full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_comb begin
    wp_nxt  = acc ? !wp_r : wp_r;
    rp_nxt  = (cmd_pop && cmd_valid) ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(acc) - 2'(cmd_pop && cmd_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q_r[wp_r] <= dec;
    end
  end

endmodule
`default_nettype wire

// File: sv/tksr_back.sv
`timescale 1ns / 1ps
`default_nettype none
module tksr_back #(
  parameter int MAX_ENTRIES = 64,
  parameter int SCORE_BITS  = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  input  wire tksr_pkg::cmd_t cmd,
  output logic               cmd_pop,
  output logic               out_empty,
  input  wire logic          out_pop,
  output logic [1:0]         out_status,
  output logic [15:0]        out_ranked_id,
  output logic [6:0]         out_match_count,
  output logic [23:0]        out_average_fixed,
  output logic               out_is_last
);
  import tksr_pkg::*;

  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_W  = SCORE_BITS + CNT_W;
  localparam int DIV_W  = SUM_W + FRAC_W;
  localparam int DBIT_W = $clog2(DIV_W + 1);
  localparam int CMP_W  = (SCORE_BITS > IN_SC_W) ? SCORE_BITS : IN_SC_W;
  localparam int RAM_W  = ID_W + SCORE_BITS;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  op_e_t                kind_r, kind_nxt;
  logic                 full_r, full_nxt;
  logic                 none_r, none_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [MAX_ENTRIES-1:0] used_r, used_nxt;
  logic [IDX_W-1:0]     iss_r, iss_nxt;
  logic                 iss_done_r, iss_done_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 best_vld_r, best_vld_nxt;
  logic [SCORE_BITS-1:0] best_sc_r, best_sc_nxt;
  logic [ID_W-1:0]      best_id_r, best_id_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic [K_W-1:0]       left_r, left_nxt;
  logic [CNT_W-1:0]     match_r, match_nxt;
  logic [CMP_W-1:0]     lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CNT_W:0]       rem_r, rem_nxt;
  logic [DIV_W-1:0]     dvd_r, dvd_nxt, quo_r, quo_nxt;
  logic [DBIT_W-1:0]    dbit_r, dbit_nxt;

  logic                 ov_r, ov_nxt;
  logic [1:0]           os_r, os_nxt;
  logic [ID_W-1:0]      oid_r, oid_nxt;
  logic [K_W-1:0]       om_r, om_nxt;
  logic [AVG_W-1:0]     oa_r, oa_nxt;
  logic                 ol_r, ol_nxt;

  logic                 we;
  logic [IDX_W-1:0]     waddr;
  logic [RAM_W-1:0]     wdata, rdata;
  logic [SCORE_BITS-1:0] rd_sc, new_sc;
  logic [ID_W-1:0]      rd_id;
  logic [CMP_W-1:0]     sc_ext, in_sc_ext;
  logic [K_W-1:0]       cnt_k, k_eff;
  logic [CNT_W:0]       rem_sh;
  logic                 out_free, ahead, last_rd;

  tksr_ram #(.WIDTH(RAM_W), .DEPTH(MAX_ENTRIES)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(iss_r),
    .rdata(rdata)
  );

  assign rd_id     = rdata[RAM_W-1 -: ID_W];
  assign rd_sc     = rdata[SCORE_BITS-1:0];
  assign sc_ext    = CMP_W'(rd_sc);
  assign in_sc_ext = CMP_W'(cmd.entry_score);
  assign new_sc    = in_sc_ext[SCORE_BITS-1:0];
  assign cnt_k     = K_W'(cnt_r);
  assign k_eff     = (cmd.top_count > cnt_k) ? cnt_k : cmd.top_count;
  assign out_free  = !ov_r || out_pop;
  assign ahead     = (rd_sc > best_sc_r) || ((rd_sc == best_sc_r) && (rd_id < best_id_r));
  assign last_rd   = (CNT_W'(rd_idx_r) == cnt_r - CNT_W'(1));
  assign rem_sh    = {rem_r[CNT_W-1:0], dvd_r[DIV_W-1]};

  assign waddr = cnt_r[IDX_W-1:0];
  assign wdata = {cmd.entry_id, new_sc};

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    full_nxt     = full_r;
    none_nxt     = none_r;
    cnt_nxt      = cnt_r;
    sum_nxt      = sum_r;
    used_nxt     = used_r;
    iss_nxt      = iss_r;
    iss_done_nxt = iss_done_r;
    rd_vld_nxt   = 1'b0;
    rd_idx_nxt   = rd_idx_r;
    best_vld_nxt = best_vld_r;
    best_sc_nxt  = best_sc_r;
    best_id_nxt  = best_id_r;
    best_idx_nxt = best_idx_r;
    left_nxt     = left_r;
    match_nxt    = match_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    rem_nxt      = rem_r;
    dvd_nxt      = dvd_r;
    quo_nxt      = quo_r;
    dbit_nxt     = dbit_r;
    ov_nxt       = ov_r && !out_pop;
    os_nxt       = os_r;
    oid_nxt      = oid_r;
    om_nxt       = om_r;
    oa_nxt       = oa_r;
    ol_nxt       = ol_r;
    cmd_pop      = 1'b0;
    we           = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop      = 1'b1;
          kind_nxt     = cmd.kind;
          none_nxt     = 1'b0;
          full_nxt     = 1'b0;
          iss_nxt      = '0;
          iss_done_nxt = 1'b0;
          best_vld_nxt = 1'b0;
          match_nxt    = '0;
          lo_nxt       = CMP_W'(cmd.range_low);
          hi_nxt       = CMP_W'(cmd.range_high);
          case (cmd.kind)
            OP_INSERT: begin
              if (cnt_r == CNT_W'(MAX_ENTRIES)) begin
                full_nxt = 1'b1;
              end else begin
                we      = 1'b1;
                cnt_nxt = cnt_r + CNT_W'(1);
                sum_nxt = sum_r + SUM_W'(new_sc);
              end
              state_nxt = S_EMIT;
            end
            OP_TOPK: begin
              used_nxt = '0;
              left_nxt = k_eff;
              if (k_eff == '0) begin
                none_nxt  = 1'b1;
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_RANGE: begin
              state_nxt = (cnt_r == '0) ? S_EMIT : S_SCAN;
            end
            default: begin
              dvd_nxt  = {sum_r, FRAC_W'(0)};
              rem_nxt  = '0;
              quo_nxt  = '0;
              dbit_nxt = DBIT_W'(DIV_W);
              state_nxt = (cnt_r == '0) ? S_EMIT : S_DIV;
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue one read a cycle, evaluate the previous one
        if (!iss_done_r) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = iss_r;
          if (CNT_W'(iss_r) == cnt_r - CNT_W'(1)) begin
            iss_done_nxt = 1'b1;
          end else begin
            iss_nxt = iss_r + IDX_W'(1);
          end
        end
        if (rd_vld_r) begin
          if (kind_r == OP_TOPK) begin
            if (!used_r[rd_idx_r] && (!best_vld_r || ahead)) begin
              best_vld_nxt = 1'b1;
              best_sc_nxt  = rd_sc;
              best_id_nxt  = rd_id;
              best_idx_nxt = rd_idx_r;
            end
          end else if (sc_ext >= lo_r && sc_ext <= hi_r) begin
            match_nxt = match_r + CNT_W'(1);
          end
          if (last_rd) begin
            state_nxt = S_EMIT;
          end
        end
      end

      S_DIV: begin
        // restoring division, one quotient bit a cycle
        dvd_nxt = {dvd_r[DIV_W-2:0], 1'b0};
        if (rem_sh >= {1'b0, cnt_r}) begin
          rem_nxt = rem_sh - {1'b0, cnt_r};
          quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
        end
        dbit_nxt = dbit_r - DBIT_W'(1);
        if (dbit_r == DBIT_W'(1)) begin
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          os_nxt    = ST_OK;
          oid_nxt   = '0;
          om_nxt    = '0;
          oa_nxt    = '0;
          ol_nxt    = 1'b1;
          state_nxt = S_IDLE;
          case (kind_r)
            OP_INSERT: begin
              if (full_r) begin
                os_nxt = ST_FULL;
              end
            end
            OP_TOPK: begin
              if (none_r) begin
                os_nxt = ST_NONE;
              end else begin
                oid_nxt  = best_id_r;
                ol_nxt   = (left_r == K_W'(1));
                used_nxt = used_r | (MAX_ENTRIES'(1) << best_idx_r);
                left_nxt = left_r - K_W'(1);
                if (left_r != K_W'(1)) begin
                  iss_nxt      = '0;
                  iss_done_nxt = 1'b0;
                  best_vld_nxt = 1'b0;
                  state_nxt    = S_SCAN;
                end
              end
            end
            OP_RANGE: begin
              om_nxt = K_W'(match_r);
            end
            default: begin
              oa_nxt = AVG_W'(quo_r);
            end
          endcase
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      sum_r   <= '0;
      ov_r    <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      ov_r    <= ov_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    full_r     <= full_nxt;
    none_r     <= none_nxt;
    used_r     <= used_nxt;
    iss_r      <= iss_nxt;
    iss_done_r <= iss_done_nxt;
    rd_idx_r   <= rd_idx_nxt;
    best_vld_r <= best_vld_nxt;
    best_sc_r  <= best_sc_nxt;
    best_id_r  <= best_id_nxt;
    best_idx_r <= best_idx_nxt;
    left_r     <= left_nxt;
    match_r    <= match_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    quo_r      <= quo_nxt;
    dbit_r     <= dbit_nxt;
    os_r       <= os_nxt;
    oid_r      <= oid_nxt;
    om_r       <= om_nxt;
    oa_r       <= oa_nxt;
    ol_r       <= ol_nxt;
  end

  assign out_empty         = !ov_r;
  assign out_status        = os_r;
  assign out_ranked_id     = oid_r;
  assign out_match_count   = om_r;
  assign out_average_fixed = oa_r;
  assign out_is_last       = ol_r;

endmodule
`default_nettype wire

// File: sv/top_k_score_ranker_top.sv
`timescale 1ns / 1ps
`default_nettype none
// top-k score ranker: keeps up to MAX_ENTRIES (id, score) entries in one ram
// and serves four operations: insert, top-k listing (score descending, then
// id ascending), inclusive range count and mean score with 8 fraction bits.
// a two-item command queue sits between the front end and the execution
// engine, and a result register sits on the output, so both sides stall on
// their own. top-k makes one full pass over the ram per reported id, at one
// read per cycle, and range count makes one such pass; the average comes
// from a bit-serial restoring divider.
module top_k_score_ranker_top #(
  parameter int MAX_ENTRIES = 64,
  parameter int SCORE_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input queue side
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_op,
  input  wire logic [15:0] in_entry_id,
  input  wire logic [15:0] in_entry_score,
  input  wire logic [6:0]  in_top_count,
  input  wire logic [15:0] in_range_low,
  input  wire logic [15:0] in_range_high,
  // result queue side
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [1:0]       out_status,
  output logic [15:0]      out_ranked_id,
  output logic [6:0]       out_match_count,
  output logic [23:0]      out_average_fixed,
  output logic             out_is_last
);
  import tksr_pkg::*;

  // decoded commands from front to back
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // front end: accepts items and decodes them into the command queue
  tksr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_op         (in_op),
    .in_entry_id   (in_entry_id),
    .in_entry_score(in_entry_score),
    .in_top_count  (in_top_count),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  // back end: entry table, scans, divider and result register
  tksr_back #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .SCORE_BITS (SCORE_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_status       (out_status),
    .out_ranked_id    (out_ranked_id),
    .out_match_count  (out_match_count),
    .out_average_fixed(out_average_fixed),
    .out_is_last      (out_is_last)
  );

endmodule
`default_nettype wire

// File: verif/tb_top_k_score_ranker_top.sv
`timescale 1ns / 1ps
module tb_top_k_score_ranker_top;
  import tksr_pkg::*;

  localparam int TABLE_DEPTH = 64;
  // slowest item: a full top-k of 64 ids, one pass over the table each, plus stalls
  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [1:0]  in_op;
  logic [15:0] in_entry_id;
  logic [15:0] in_entry_score;
  logic [6:0]  in_top_count;
  logic [15:0] in_range_low;
  logic [15:0] in_range_high;
  logic        out_empty;
  logic        out_pop;
  logic [1:0]  out_status;
  logic [15:0] out_ranked_id;
  logic [6:0]  out_match_count;
  logic [23:0] out_average_fixed;
  logic        out_is_last;

  top_k_score_ranker_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_op(in_op),
    .in_entry_id(in_entry_id), .in_entry_score(in_entry_score),
    .in_top_count(in_top_count), .in_range_low(in_range_low),
    .in_range_high(in_range_high),
    .out_empty(out_empty), .out_pop(out_pop), .out_status(out_status),
    .out_ranked_id(out_ranked_id), .out_match_count(out_match_count),
    .out_average_fixed(out_average_fixed), .out_is_last(out_is_last)
  );

  // one expected result item
  typedef struct {
    status_e_t   status;
    logic [15:0] ranked_id;
    logic [6:0]  match_count;
    logic [23:0] average_fixed;
    logic        is_last;
  } ranker_result_t;

  // shadow copy of the ranking table
  logic [15:0] shadow_id[TABLE_DEPTH];
  logic [15:0] shadow_score[TABLE_DEPTH];
  int unsigned shadow_count;
  longint unsigned shadow_sum;

  ranker_result_t pending_results[$];
  int unsigned    error_count;
  int unsigned    idle_cycles;

  // idling controls
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          recv_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic ranker_result_t make_result(status_e_t st, logic [15:0] id,
                                                 logic [6:0] cnt, logic [23:0] avg,
                                                 logic last);
    ranker_result_t r;
    r.status        = st;
    r.ranked_id     = id;
    r.match_count   = cnt;
    r.average_fixed = avg;
    r.is_last       = last;
    return r;
  endfunction

  // appends one expectation at the tail of the queue
  function automatic void add_expected(ranker_result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // predicts the results of one accepted item and updates the shadow table
  task automatic predict_ranking(op_e_t op, logic [15:0] id, logic [15:0] score,
                                 logic [6:0] k, logic [15:0] lo, logic [15:0] hi);
    bit          taken[TABLE_DEPTH];
    int unsigned want;
    int          best;
    int unsigned hits;
    case (op)
      OP_INSERT: begin
        if (shadow_count >= TABLE_DEPTH) begin
          add_expected(make_result(ST_FULL, '0, '0, '0, 1'b1));
        end else begin
          shadow_id[shadow_count]    = id;
          shadow_score[shadow_count] = score;
          shadow_sum += score;
          shadow_count++;
          add_expected(make_result(ST_OK, '0, '0, '0, 1'b1));
        end
      end
      OP_TOPK: begin
        want = (k > shadow_count) ? shadow_count : k;
        if (want == 0) begin
          add_expected(make_result(ST_NONE, '0, '0, '0, 1'b1));
        end else begin
          foreach (taken[i]) taken[i] = 1'b0;
          for (int r = 0; r < want; r++) begin
            best = -1;
            for (int i = 0; i < shadow_count; i++) begin
              if (taken[i]) continue;
              // score descending, then id ascending
              if (best < 0 || shadow_score[i] > shadow_score[best] ||
                  (shadow_score[i] == shadow_score[best] &&
                   shadow_id[i] < shadow_id[best]))
                best = i;
            end
            taken[best] = 1'b1;
            add_expected(make_result(ST_OK, shadow_id[best], '0, '0, r + 1 == want));
          end
        end
      end
      OP_RANGE: begin
        hits = 0;
        for (int i = 0; i < shadow_count; i++)
          if (shadow_score[i] >= lo && shadow_score[i] <= hi) hits++;
        add_expected(make_result(ST_OK, '0, hits[6:0], '0, 1'b1));
      end
      default: begin
        add_expected(make_result(ST_OK, '0, '0,
          (shadow_count == 0) ? 24'd0 : 24'((shadow_sum << 8) / shadow_count),
          1'b1));
      end
    endcase
  endtask

  // offers one item until the block takes it, idling first at random;
  // returns at a falling edge with push still high, so the caller either
  // offers the next item or drops push at that edge
  task automatic send_item(op_e_t op, logic [15:0] id, logic [15:0] score,
                           logic [6:0] k, logic [15:0] lo, logic [15:0] hi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push        <= 1'b1;
    in_op          <= op;
    in_entry_id    <= id;
    in_entry_score <= score;
    in_top_count   <= k;
    in_range_low   <= lo;
    in_range_high  <= hi;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_ranking(op, id, score, k, lo, hi);
    @(negedge clk);
  endtask

  // random item with field values spread over the extremes
  function automatic logic [15:0] pick_score();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(15)); // dense, to force ties
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_item(int unsigned insert_weight);
    op_e_t op;
    int unsigned roll;
    logic [15:0] a, b;
    roll = $urandom_range(99);
    if (roll < insert_weight) op = OP_INSERT;
    else op = op_e_t'($urandom_range(1, 3));
    a = pick_score();
    b = pick_score();
    if ($urandom_range(3) != 0 && a > b) {a, b} = {b, a};
    // k is small mostly, so top-k does not dominate the run
    send_item(op, ($urandom_range(3) == 0) ? 16'($urandom_range(7)) : 16'($urandom),
              pick_score(),
              ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(8)),
              a, b);
  endtask

  // stops offering and waits until every expected result has come
  task automatic drain_results();
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // reset clears the table; the only way back to an empty state
  task automatic fill_check_table_limits();
    send_item(OP_TOPK, '0, '0, 7'd5, '0, '0);      // empty table, nothing to list
    send_item(OP_AVG, '0, '0, '0, '0, '0);         // average of empty table
    send_item(OP_RANGE, '0, '0, '0, '0, 16'hFFFF); // count on empty table
    send_item(OP_INSERT, 16'hFFFF, 16'hFFFF, '0, '0, '0);
    send_item(OP_INSERT, 16'h0000, 16'h0000, '0, '0, '0);
    send_item(OP_INSERT, 16'h0001, 16'hFFFF, '0, '0, '0); // score tie
    send_item(OP_INSERT, 16'h0001, 16'hFFFF, '0, '0, '0); // equal score and id
    send_item(OP_TOPK, '0, '0, 7'd0, '0, '0);       // k zero
    send_item(OP_TOPK, '0, '0, 7'd127, '0, '0);     // k above count
    send_item(OP_TOPK, '0, '0, 7'd2, '0, '0);
    send_item(OP_RANGE, '0, '0, '0, 16'h0005, 16'h0004); // low above high
    send_item(OP_RANGE, '0, '0, '0, 16'hFFFF, 16'hFFFF);
    send_item(OP_RANGE, '0, '0, '0, 16'h0000, 16'h0000);
    send_item(OP_AVG, '0, '0, '0, '0, '0);
    drain_results();
  endtask

  // random traffic over four idling phases
  task automatic random_traffic_phases();
    int unsigned idle_pct[4]  = '{0, 64, 0, 12};
    int unsigned stall_pct[4] = '{0, 0, 64, 12};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      for (int n = 0; n < 85; n++) send_random_item(60);
      drain_results();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // receiver holds off while items keep coming, so the input side backs up
  task automatic backpressure_burst();
    recv_hold = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        recv_hold = 1'b0;
      end
      for (int n = 0; n < 40; n++) send_random_item(70);
    join
    drain_results();
  endtask

  // fills the table past its limit, then queries a full table
  task automatic full_table_queries();
    send_idle_pct  = 12;
    recv_stall_pct = 12;
    while (shadow_count < TABLE_DEPTH) send_random_item(100);
    for (int n = 0; n < 4; n++) send_item(OP_INSERT, 16'($urandom), 16'($urandom),
                                          '0, '0, '0);
    send_item(OP_TOPK, '0, '0, 7'd64, '0, '0);
    send_item(OP_TOPK, '0, '0, 7'd127, '0, '0);
    send_item(OP_RANGE, '0, '0, '0, 16'h0000, 16'hFFFF);
    send_item(OP_AVG, '0, '0, '0, '0, '0);
    for (int n = 0; n < 60; n++) send_random_item(20);
    drain_results();
  endtask

  // result side: pop at random, compare against the oldest expectation
  always @(negedge clk) begin
    if (!rst_n) out_pop <= 1'b0;
    else out_pop <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    ranker_result_t exp_r;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected");
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status) begin
          $error("status exp %0d act %0d", exp_r.status, out_status);
          error_count++;
        end
        if (out_ranked_id !== exp_r.ranked_id) begin
          $error("ranked_id exp %0h act %0h", exp_r.ranked_id, out_ranked_id);
          error_count++;
        end
        if (out_match_count !== exp_r.match_count) begin
          $error("match_count exp %0d act %0d", exp_r.match_count, out_match_count);
          error_count++;
        end
        if (out_average_fixed !== exp_r.average_fixed) begin
          $error("average_fixed exp %0h act %0h", exp_r.average_fixed,
                 out_average_fixed);
          error_count++;
        end
        if (out_is_last !== exp_r.is_last) begin
          $error("is_last exp %0b act %0b", exp_r.is_last, out_is_last);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_op = OP_INSERT;
    in_entry_id = '0;
    in_entry_score = '0;
    in_top_count = '0;
    in_range_low = '0;
    in_range_high = '0;
    recv_hold = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    error_count = 0;
    idle_cycles = 0;
    shadow_count = 0;
    shadow_sum = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    fill_check_table_limits();
    random_traffic_phases();
    backpressure_burst();
    full_table_queries();

    // nothing left expected; let the block settle before the verdict
    repeat (200) @(negedge clk);
    if (error_count == 0 && pending_results.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
